/* hdl/tpc_pkg.sv */
`timescale 1ns / 1ps

package tpc_pkg;

  // pool and alphabet
  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int FREE_W        = NODE_W + 1;
  localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);

  // field widths
  localparam int OPCODE_W = 2;
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // node word: word-end mark above the prefix count
  localparam int NODE_WORD_W = COUNT_W + 1;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [FREE_W-1:0]   free_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  typedef struct packed {
    logic   word_end;
    count_t prefix_count;
  } node_word_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_COUNT  = 2'd1;
  localparam opcode_t OP_EXISTS = 2'd2;
  localparam opcode_t OP_UNUSED = 2'd3;

endpackage

/* hdl/trie_insert_and_prefix_count_unit.sv */
`timescale 1ns / 1ps

// Trie engine over a pool of 4096 nodes and a 26-letter alphabet. A string
// arrives one letter per input transfer with an opcode (insert, count prefix,
// test whole string) and a last mark; one result transfer follows each
// string's last letter (none for the unused opcode). After reset the block
// sweeps all 106496 entries of the child link memory to zero, one entry per
// cycle, with in_ready low. Each letter then passes through the child link
// read and the retire step when it needs no node access (missing link,
// newly allocated node, pool exhausted, or a string already off the trie),
// and through the child link read, a node memory read-modify-write and the
// retire step when an existing node is read and updated. A finished result
// waits in the output register; the next letter is taken meanwhile, and
// only a following last letter waits for it. Prefix counts saturate at
// 65535. Node words need no clearing: a node is written whole when it is
// allocated.

module trie_insert_and_prefix_count_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tpc_pkg::opcode_t in_opcode,
  input  tpc_pkg::letter_t in_letter,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output tpc_pkg::count_t  out_prefix_count,
  output logic             out_found,
  output logic             out_pool_full
);

  import tpc_pkg::*;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a letter
  localparam logic [1:0] S_LINK = 2'd1;  // child link read data back
  localparam logic [1:0] S_NODE = 2'd2;  // node word read data back
  localparam logic [1:0] S_FIN  = 2'd3;  // retire letter, emit result

  logic [1:0] state_r, state_nxt;

  // clearing sweep of the link memory
  logic  clr_busy_r, clr_busy_nxt;
  slot_t clr_addr_r, clr_addr_nxt;

  // captured letter
  opcode_t op_r, op_nxt;
  letter_t let_r, let_nxt;
  logic    last_r, last_nxt;
  slot_t   slot_r, slot_nxt;
  node_t   child_r, child_nxt;

  // walk state
  node_t  cur_node_r, cur_node_nxt;
  free_t  next_free_r, next_free_nxt;
  logic   missing_r, missing_nxt;
  count_t running_r, running_nxt;
  logic   overflow_r, overflow_nxt;
  logic   end_r, end_nxt;

  // result register
  logic   out_valid_r, out_valid_nxt;
  count_t out_count_r, out_count_nxt;
  logic   out_found_r, out_found_nxt;
  logic   out_full_r, out_full_nxt;

  // memory ports
  logic       link_we, link_re;
  slot_t      link_waddr, link_raddr;
  node_t      link_wdata, link_q;
  logic       node_we, node_re;
  node_t      node_waddr, node_raddr;
  node_word_t node_wdata, node_q;

  logic  in_xfer;
  logic  in_let_ok, let_ok;
  slot_t slot_calc;
  node_t link_child;
  logic  out_free;

  tpc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (link_re),
    .rd_addr (link_raddr),
    .rd_data (link_q)
  );

  tpc_ram #(
    .WIDTH (NODE_WORD_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_en   (node_re),
    .rd_addr (node_raddr),
    .rd_data (node_q)
  );

  assign in_ready  = (state_r == S_IDLE) && !clr_busy_r;
  assign in_xfer   = in_valid && in_ready;
  assign in_let_ok = in_letter < LETTER_W'(ALPHABET_SIZE);
  assign let_ok    = let_r < LETTER_W'(ALPHABET_SIZE);
  assign out_free  = !out_valid_r || out_ready;

  // slot of this letter under the current node
  assign slot_calc = SLOT_W'(cur_node_r) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(in_letter);

  // a letter outside the alphabet has no link
  assign link_child = let_ok ? link_q : '0;

  assign link_re    = in_xfer;
  assign link_raddr = in_let_ok ? slot_calc : '0;

  always_comb begin
    state_nxt     = state_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    let_nxt       = let_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    child_nxt     = child_r;
    cur_node_nxt  = cur_node_r;
    next_free_nxt = next_free_r;
    missing_nxt   = missing_r;
    running_nxt   = running_r;
    overflow_nxt  = overflow_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;

    link_we    = 1'b0;
    link_waddr = slot_r;
    link_wdata = '0;
    node_we    = 1'b0;
    node_waddr = child_r;
    node_wdata = node_q;
    node_re    = 1'b0;
    node_raddr = link_q;

    // result leaves on its transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // zero sweep after reset
    if (clr_busy_r) begin
      link_we      = 1'b1;
      link_waddr   = clr_addr_r;
      link_wdata   = '0;
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == SLOT_W'(SLOT_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_opcode;
          let_nxt   = in_letter;
          last_nxt  = in_last;
          slot_nxt  = slot_calc;
          state_nxt = S_LINK;
        end
      end

      S_LINK: begin
        state_nxt = S_FIN;
        if (op_r == OP_INSERT) begin
          if (!overflow_r) begin
            if (!let_ok) begin
              overflow_nxt = 1'b1;
            end else if (link_q == '0) begin
              if (next_free_r >= FREE_W'(NODE_COUNT)) begin
                overflow_nxt = 1'b1;
              end else begin
                // allocate: link it and write the fresh node whole
                link_we       = 1'b1;
                link_waddr    = slot_r;
                link_wdata    = next_free_r[NODE_W-1:0];
                node_we       = 1'b1;
                node_waddr    = next_free_r[NODE_W-1:0];
                node_wdata    = '{word_end: last_r, prefix_count: COUNT_W'(1)};
                cur_node_nxt  = next_free_r[NODE_W-1:0];
                next_free_nxt = next_free_r + 1'b1;
              end
            end else begin
              node_re    = 1'b1;
              node_raddr = link_q;
              child_nxt  = link_q;
              state_nxt  = S_NODE;
            end
          end
        end else if (op_r == OP_COUNT || op_r == OP_EXISTS) begin
          if (!missing_r) begin
            if (link_child == '0) begin
              missing_nxt = 1'b1;
              running_nxt = '0;
            end else begin
              node_re    = 1'b1;
              node_raddr = link_child;
              child_nxt  = link_child;
              state_nxt  = S_NODE;
            end
          end
        end
      end

      S_NODE: begin
        cur_node_nxt = child_r;
        if (op_r == OP_INSERT) begin
          node_we    = 1'b1;
          node_waddr = child_r;
          node_wdata.word_end = node_q.word_end | last_r;
          node_wdata.prefix_count = (node_q.prefix_count == COUNT_MAX) ?
                                    node_q.prefix_count :
                                    node_q.prefix_count + 1'b1;
        end else begin
          running_nxt = node_q.prefix_count;
          end_nxt     = node_q.word_end;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (op_r == OP_UNUSED || out_free) begin
          if (op_r != OP_UNUSED) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = (op_r == OP_COUNT && !missing_r) ? running_r : '0;
            out_found_nxt = (op_r == OP_EXISTS) && !missing_r && end_r;
            out_full_nxt  = (op_r == OP_INSERT) && overflow_r;
          end
          // string ends: walk state back to the root
          cur_node_nxt = '0;
          missing_nxt  = 1'b0;
          running_nxt  = '0;
          overflow_nxt = 1'b0;
          end_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      cur_node_r  <= '0;
      next_free_r <= FREE_W'(1);
      missing_r   <= 1'b0;
      running_r   <= '0;
      overflow_r  <= 1'b0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_node_r  <= cur_node_nxt;
      next_free_r <= next_free_nxt;
      missing_r   <= missing_nxt;
      running_r   <= running_nxt;
      overflow_r  <= overflow_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    let_r       <= let_nxt;
    last_r      <= last_nxt;
    slot_r      <= slot_nxt;
    child_r     <= child_nxt;
    out_count_r <= out_count_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_prefix_count = out_count_r;
  assign out_found        = out_found_r;
  assign out_pool_full    = out_full_r;

endmodule

/* hdl/tpc_ram.sv */
`timescale 1ns / 1ps

module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
